FILE: hdl/lscs_pkg.sv
`timescale 1ns / 1ps

package lscs_pkg;

    // item kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_DATA    = 2'd1,
        OP_ACK     = 2'd2,
        OP_UNKNOWN = 2'd3
    } op_t;

    // link status events
    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_ONLINE  = 2'd1,
        EVT_OFFLINE = 2'd2,
        EVT_RSVD    = 2'd3
    } status_evt_t;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [1:0] CFG_HOP         = 2'd1;
    localparam logic [1:0] CFG_CLOCK_FLOOR = 2'd2;

    // configuration reset values
    localparam logic [19:0] TIMEOUT_RST     = 20'd15000;
    localparam logic [15:0] HOP_RST         = 16'd250;
    localparam logic [31:0] CLOCK_FLOOR_RST = 32'd1000000000;

    typedef struct packed {
        logic [19:0] timeout_ms;
        logic [15:0] hop_interval_ms;
        logic [31:0] clock_floor;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [47:0] sender_mac;
        logic [7:0]  hub_channel;
        logic [7:0]  packet_seq;
        logic [31:0] stamp_seconds;
    } item_t;

    typedef struct packed {
        logic        send_ack;
        logic [7:0]  reply_seq;
        logic [47:0] reply_mac;
        logic        set_channel;
        logic [3:0]  radio_channel;
        status_evt_t status_event;
        logic        set_clock;
        logic [31:0] clock_seconds;
        logic        hub_learned;
        logic        deliver_data;
        logic        ack_received;
        logic [31:0] drops;
    } result_t;

endpackage

FILE: hdl/lscs_core.sv
`timescale 1ns / 1ps

module lscs_core #(
    parameter int CHANNEL_COUNT = 13
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  lscs_pkg::item_t item,
    input  lscs_pkg::cfg_t  cfg,
    output lscs_pkg::result_t result
);
    import lscs_pkg::*;

    localparam logic [3:0] CH_MAX = 4'(CHANNEL_COUNT);

    logic        online_reg,    online_next;
    logic [3:0]  locked_reg,    locked_next;
    logic [3:0]  scan_reg,      scan_next;
    logic [31:0] last_rx_reg,   last_rx_next;
    logic [31:0] last_hop_reg,  last_hop_next;
    logic        seq_valid_reg, seq_valid_next;
    logic [7:0]  prev_seq_reg,  prev_seq_next;
    logic [31:0] drop_reg,      drop_next;
    logic        hub_known_reg, hub_known_next;

    logic [31:0] rx_elapsed;
    logic [31:0] hop_elapsed;
    logic        link_lost;
    logic        hop_due;
    logic [3:0]  scan_inc;
    logic        chan_ok;
    logic        chan_change;
    logic [7:0]  seq_diff;
    logic        seq_check;

    // elapsed times and decisions shared by next state and result
    always_comb begin
        rx_elapsed  = item.now_ms - last_rx_reg;
        hop_elapsed = item.now_ms - last_hop_reg;
        link_lost   = rx_elapsed > {12'd0, cfg.timeout_ms};
        hop_due     = hop_elapsed > {16'd0, cfg.hop_interval_ms};
        scan_inc    = (scan_reg + 4'd1 > CH_MAX) ? 4'd1 : scan_reg + 4'd1;
        chan_ok     = (item.hub_channel != 8'd0) && (item.hub_channel <= {4'd0, CH_MAX});
        chan_change = chan_ok && (item.hub_channel[3:0] != locked_reg);
        seq_diff    = item.packet_seq - prev_seq_reg;
        seq_check   = seq_valid_reg && !chan_change;
    end

    // next state and result for the word at the input
    always_comb begin
        online_next    = online_reg;
        locked_next    = locked_reg;
        scan_next      = scan_reg;
        last_rx_next   = last_rx_reg;
        last_hop_next  = last_hop_reg;
        seq_valid_next = seq_valid_reg;
        prev_seq_next  = prev_seq_reg;
        drop_next      = drop_reg;
        hub_known_next = hub_known_reg;
        result         = '0;

        case (item.op)
            OP_TICK: begin
                if (online_reg) begin
                    if (link_lost) begin
                        online_next         = 1'b0;
                        locked_next         = 4'd0;
                        scan_next           = CH_MAX;
                        result.status_event = EVT_OFFLINE;
                    end
                end else if (hop_due) begin
                    last_hop_next        = item.now_ms;
                    scan_next            = scan_inc;
                    result.set_channel   = 1'b1;
                    result.radio_channel = scan_inc;
                end
            end
            OP_DATA: begin
                if (chan_change) begin
                    locked_next          = item.hub_channel[3:0];
                    seq_valid_next       = 1'b0;
                    result.set_channel   = 1'b1;
                    result.radio_channel = item.hub_channel[3:0];
                end
                last_rx_next = item.now_ms;
                if (!online_reg) begin
                    online_next         = 1'b1;
                    result.status_event = EVT_ONLINE;
                end
                if (item.stamp_seconds > cfg.clock_floor) begin
                    result.set_clock     = 1'b1;
                    result.clock_seconds = item.stamp_seconds;
                end
                if (!hub_known_reg) begin
                    hub_known_next     = 1'b1;
                    result.hub_learned = 1'b1;
                end
                // count missing sequence numbers; a repeat adds none
                if (seq_check) begin
                    if (seq_diff > 8'd1) begin
                        drop_next = drop_reg + {24'd0, seq_diff} - 32'd1;
                    end
                end
                seq_valid_next      = 1'b1;
                prev_seq_next       = item.packet_seq;
                result.deliver_data = 1'b1;
                result.send_ack     = 1'b1;
                result.reply_seq    = item.packet_seq;
                result.reply_mac    = item.sender_mac;
            end
            OP_ACK: begin
                result.ack_received = 1'b1;
                result.reply_seq    = item.packet_seq;
            end
            default: begin
            end
        endcase

        result.drops = drop_next;
    end

    // commit state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            online_reg    <= 1'b0;
            locked_reg    <= 4'd0;
            scan_reg      <= CH_MAX;
            last_rx_reg   <= 32'd0;
            last_hop_reg  <= 32'd0;
            seq_valid_reg <= 1'b0;
            prev_seq_reg  <= 8'd0;
            drop_reg      <= 32'd0;
            hub_known_reg <= 1'b0;
        end else if (accept) begin
            online_reg    <= online_next;
            locked_reg    <= locked_next;
            scan_reg      <= scan_next;
            last_rx_reg   <= last_rx_next;
            last_hop_reg  <= last_hop_next;
            seq_valid_reg <= seq_valid_next;
            prev_seq_reg  <= prev_seq_next;
            drop_reg      <= drop_next;
            hub_known_reg <= hub_known_next;
        end
    end

endmodule

FILE: hdl/link_supervisor_channel_scan.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake         Payload
// s_        in         tvalid / tready   tuser: op; tdata: item fields (128 bits)
// m_        out        tvalid / tready   tdata: result fields (136 bits)
// cfg_      in         cfg_we            cfg_index, cfg_wdata (32 bits)
//
// One word is accepted per cycle while the skid register is empty; its result is registered for m_.
// The state update and result logic is a single combinational pass from
// the input word and the supervisor state into the output or skid register.
// A two-entry output stage (output register plus skid register) keeps
// s_tready registered; a stall holds s_tready low only once both are full.
// aresetn is synchronous, active low; it restores the state, the configuration and the valid flags, not the payloads.

module link_supervisor_channel_scan #(
    parameter int CHANNEL_COUNT = 13
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] now_ms[31:0], [32] sender_mac[47:0], [80] hub_channel[7:0],
    // [88] packet_seq[7:0], [96] stamp_seconds[31:0]
    input  logic [127:0] s_tdata,
    // [0] op[1:0]
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] send_ack, [1] reply_seq[7:0], [9] reply_mac[47:0], [57] set_channel,
    // [58] radio_channel[3:0], [62] status_event[1:0], [64] set_clock,
    // [65] clock_seconds[31:0], [97] hub_learned, [98] deliver_data,
    // [99] ack_received, [100] drops[31:0], [132] zero fill[3:0]
    output logic [135:0] m_tdata,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import lscs_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms      <= TIMEOUT_RST;
            cfg_reg.hop_interval_ms <= HOP_RST;
            cfg_reg.clock_floor     <= CLOCK_FLOOR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT:     cfg_reg.timeout_ms      <= cfg_wdata[19:0];
                CFG_HOP:         cfg_reg.hop_interval_ms <= cfg_wdata[15:0];
                CFG_CLOCK_FLOOR: cfg_reg.clock_floor     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // unpack the input word
    always_comb begin
        item.op            = op_t'(s_tuser);
        item.now_ms        = s_tdata[31:0];
        item.sender_mac    = s_tdata[79:32];
        item.hub_channel   = s_tdata[87:80];
        item.packet_seq    = s_tdata[95:88];
        item.stamp_seconds = s_tdata[127:96];
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    lscs_core #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload moves without reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_tready) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

    // pack the result word
    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata           = '0;
        m_tdata[0]        = out_reg.send_ack;
        m_tdata[8:1]      = out_reg.reply_seq;
        m_tdata[56:9]     = out_reg.reply_mac;
        m_tdata[57]       = out_reg.set_channel;
        m_tdata[61:58]    = out_reg.radio_channel;
        m_tdata[63:62]    = out_reg.status_event;
        m_tdata[64]       = out_reg.set_clock;
        m_tdata[96:65]    = out_reg.clock_seconds;
        m_tdata[97]       = out_reg.hub_learned;
        m_tdata[98]       = out_reg.deliver_data;
        m_tdata[99]       = out_reg.ack_received;
        m_tdata[131:100]  = out_reg.drops;
    end

endmodule
